### sv/ctlm_pkg.sv
// Package: shared widths, codes, reset values and divider handshake types.
package ctlm_pkg;

    localparam int CTX_COUNT  = 16;
    localparam int CTX_W      = 4;
    localparam int CTX_IDX_W  = (CTX_COUNT > 1) ? $clog2(CTX_COUNT) : 1;
    localparam int FUNC_W     = 2;
    localparam int TS_W       = 32;
    localparam int PERIOD_W   = 16;
    localparam int LOAD_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int DIV_STEPS  = LOAD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [FUNC_W-1:0] FUNC_ENTER = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_LEAVE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMER_RELOAD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INVALID_CTX    = 2'd2;

    localparam logic [TS_W-1:0]     RST_TIMER_RELOAD  = 32'hFFFF_FFFF;
    localparam logic [PERIOD_W-1:0] RST_UPDATE_PERIOD = 16'd1000;
    localparam logic [CTX_W-1:0]    RST_INVALID_CTX   = 4'hF;

    localparam logic [LOAD_W-1:0] LOAD_MAX = 16'h8000;

    typedef struct packed {
        logic            start;
        logic [TS_W-1:0] dividend;
        logic [TS_W-1:0] divisor;
    } div_cmd_t;

    typedef struct packed {
        logic              done;
        logic [LOAD_W-1:0] quotient;
    } div_stat_t;

endpackage

### sv/ctlm_if.sv
// Interfaces: event request, result request and register write channels.
interface ctlm_evt_if;
    logic                         valid;
    logic                         ready;
    logic [ctlm_pkg::FUNC_W-1:0]  func;
    logic [ctlm_pkg::CTX_W-1:0]   ctx_id;
    logic                         from_isr;
    logic                         idle_running;
    logic [ctlm_pkg::TS_W-1:0]    timestamp;

    modport source (output valid, func, ctx_id, from_isr, idle_running, timestamp,
                    input ready);
    modport sink   (input valid, func, ctx_id, from_isr, idle_running, timestamp,
                    output ready);
endinterface

interface ctlm_res_if;
    logic                         valid;
    logic                         ready;
    logic [ctlm_pkg::CTX_W-1:0]   trace_pins;
    logic [ctlm_pkg::LOAD_W-1:0]  cpu_load;
    logic                         load_updated;

    modport source (output valid, trace_pins, cpu_load, load_updated, input ready);
    modport sink   (input valid, trace_pins, cpu_load, load_updated, output ready);
endinterface

interface ctlm_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [ctlm_pkg::CFG_IDX_W-1:0]  index;
    logic [ctlm_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/context_trace_and_cpu_load_monitor.sv
// Top level: context trace pins and idle-based CPU load monitor.
//
// Channels: evt (sink) takes enter, leave and tick requests with a timestamp;
// res (source) returns exactly one result per request: trace pins, the last
// CPU load in Q1.15 and a flag that the request closed a load window; cfg
// (sink, always ready) writes timer_reload, update_period and invalid_context.
// The user must write configuration only while no request is in flight; the
// block does not enforce this. A plain enter, leave or tick passes S_DECODE
// and S_PUSH; one that adds an idle interval also passes S_DIFF, S_WRAP and
// S_ACC; a window close passes S_DIFF, S_WRAP and S_CHECK, and one that
// divides also waits in S_DIV. The divide is a restoring bit-serial unit
// with 16 quotient bits, one per cycle; it and the wraparound subtract set
// the worst case. One request is processed at a time; the next is taken as
// soon as the previous result is loaded into the output register, even while
// that result waits on a stalled receiver. A new result waits until the
// output register is free. Reset sets the configuration to its defaults,
// the current context and saved slots to context 15, counters and load to zero.
module context_trace_and_cpu_load_monitor (
    input  logic       clk,
    input  logic       rst_n,
    ctlm_evt_if.sink   evt,
    ctlm_res_if.source res,
    ctlm_cfg_if.sink   cfg
);

    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_DIFF, S_WRAP, S_ACC, S_CHECK, S_DIV, S_PUSH
    } state_t;

    state_t state_reg, state_next;

    logic [ctlm_pkg::TS_W-1:0]      reload_reg;
    logic [ctlm_pkg::PERIOD_W-1:0]  period_reg;
    logic [ctlm_pkg::CTX_W-1:0]     inv_reg;

    logic [ctlm_pkg::FUNC_W-1:0]    func_reg;
    logic [ctlm_pkg::CTX_W-1:0]     ctx_reg;
    logic                           isr_reg;
    logic                           idle_reg;
    logic [ctlm_pkg::TS_W-1:0]      ts_reg;

    logic [ctlm_pkg::CTX_W-1:0]     cur_reg, cur_next;
    logic [ctlm_pkg::CTX_W-1:0]     saved_reg [ctlm_pkg::CTX_COUNT];
    logic                           saved_we;
    logic [ctlm_pkg::TS_W-1:0]      istart_reg, istart_next;
    logic [ctlm_pkg::TS_W-1:0]      acc_reg, acc_next;
    logic [ctlm_pkg::TS_W-1:0]      win_reg, win_next;
    logic [ctlm_pkg::PERIOD_W-1:0]  tick_reg, tick_next;
    logic [ctlm_pkg::LOAD_W-1:0]    load_reg, load_next;
    logic                           upd_reg, upd_next;
    logic [ctlm_pkg::TS_W-1:0]      el_reg, el_next;
    logic                           gt_reg, gt_next;

    logic                           out_valid_reg, out_valid_next;
    logic                           out_load;
    logic [ctlm_pkg::CTX_W-1:0]     out_trace_reg;
    logic [ctlm_pkg::LOAD_W-1:0]    out_load_reg;
    logic                           out_upd_reg;

    logic [ctlm_pkg::PERIOD_W-1:0]  tick_inc;
    logic [ctlm_pkg::TS_W-1:0]      from_time;
    logic [ctlm_pkg::TS_W:0]        diff_wide;
    logic [ctlm_pkg::TS_W:0]        busy_wide;
    logic                           ctx_in_range;
    logic                           cur_in_range;
    logic [ctlm_pkg::CTX_IDX_W-1:0] ctx_idx;
    logic [ctlm_pkg::CTX_IDX_W-1:0] cur_idx;

    ctlm_pkg::div_cmd_t             div_cmd;
    ctlm_pkg::div_stat_t            div_stat;

    assign evt.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign tick_inc     = ctlm_pkg::PERIOD_W'(tick_reg + 1'b1);
    assign from_time    = (func_reg == ctlm_pkg::FUNC_TICK) ? win_reg : istart_reg;
    assign diff_wide    = {1'b0, ts_reg} - {1'b0, from_time};
    assign busy_wide    = {1'b0, el_reg} - {1'b0, acc_reg};
    assign ctx_in_range = ({1'b0, ctx_reg} < (ctlm_pkg::CTX_W + 1)'(ctlm_pkg::CTX_COUNT));
    assign cur_in_range = ({1'b0, cur_reg} < (ctlm_pkg::CTX_W + 1)'(ctlm_pkg::CTX_COUNT));
    assign ctx_idx      = ctx_reg[ctlm_pkg::CTX_IDX_W-1:0];
    assign cur_idx      = cur_reg[ctlm_pkg::CTX_IDX_W-1:0];

    assign div_cmd.start    = (state_reg == S_CHECK) && (el_reg != '0) &&
                              !busy_wide[ctlm_pkg::TS_W];
    assign div_cmd.dividend = busy_wide[ctlm_pkg::TS_W-1:0];
    assign div_cmd.divisor  = el_reg;

    ctlm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .stat  (div_stat)
    );

    always_comb
    begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        saved_we       = 1'b0;
        istart_next    = istart_reg;
        acc_next       = acc_reg;
        win_next       = win_reg;
        tick_next      = tick_reg;
        load_next      = load_reg;
        upd_next       = upd_reg;
        el_next        = el_reg;
        gt_next        = gt_reg;
        out_valid_next = out_valid_reg && !res.ready;
        out_load       = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (evt.valid)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                upd_next   = 1'b0;
                state_next = S_PUSH;
                case (func_reg)
                    ctlm_pkg::FUNC_ENTER:
                    begin
                        saved_we = ctx_in_range;
                        cur_next = ctx_reg;
                        if (idle_reg && !isr_reg)
                        begin
                            istart_next = ts_reg;
                        end
                        if (idle_reg && isr_reg)
                        begin
                            state_next = S_DIFF;
                        end
                    end
                    ctlm_pkg::FUNC_LEAVE:
                    begin
                        cur_next = cur_in_range ? saved_reg[cur_idx] : inv_reg;
                        if (idle_reg && isr_reg)
                        begin
                            istart_next = ts_reg;
                        end
                        if (idle_reg && !isr_reg)
                        begin
                            state_next = S_DIFF;
                        end
                    end
                    ctlm_pkg::FUNC_TICK:
                    begin
                        if (tick_inc >= period_reg)
                        begin
                            tick_next  = '0;
                            state_next = S_DIFF;
                        end
                        else
                        begin
                            tick_next = tick_inc;
                        end
                    end
                    default:
                    begin
                        state_next = S_PUSH;
                    end
                endcase
            end
            S_DIFF:
            begin
                el_next    = diff_wide[ctlm_pkg::TS_W-1:0];
                gt_next    = !diff_wide[ctlm_pkg::TS_W] &&
                             (diff_wide[ctlm_pkg::TS_W-1:0] != '0);
                state_next = S_WRAP;
            end
            S_WRAP:
            begin
                // timer wrapped: (reload - from) + to + 1
                if (!gt_reg)
                begin
                    el_next = el_reg + reload_reg + ctlm_pkg::TS_W'(1);
                end
                state_next = (func_reg == ctlm_pkg::FUNC_TICK) ? S_CHECK : S_ACC;
            end
            S_ACC:
            begin
                acc_next   = acc_reg + el_reg;
                state_next = S_PUSH;
            end
            S_CHECK:
            begin
                win_next   = ts_reg;
                acc_next   = '0;
                state_next = S_PUSH;
                if (el_reg != '0)
                begin
                    if (busy_wide[ctlm_pkg::TS_W])
                    begin
                        load_next = '0;
                        upd_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    load_next  = div_stat.quotient;
                    upd_next   = 1'b1;
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            reload_reg    <= ctlm_pkg::RST_TIMER_RELOAD;
            period_reg    <= ctlm_pkg::RST_UPDATE_PERIOD;
            inv_reg       <= ctlm_pkg::RST_INVALID_CTX;
            cur_reg       <= ctlm_pkg::RST_INVALID_CTX;
            for (int i = 0; i < ctlm_pkg::CTX_COUNT; i++)
            begin
                saved_reg[i] <= ctlm_pkg::RST_INVALID_CTX;
            end
            istart_reg    <= '0;
            acc_reg       <= '0;
            win_reg       <= '0;
            tick_reg      <= '0;
            load_reg      <= '0;
            upd_reg       <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    ctlm_pkg::CFG_TIMER_RELOAD:
                        reload_reg <= cfg.data[ctlm_pkg::TS_W-1:0];
                    ctlm_pkg::CFG_UPDATE_PERIOD:
                        period_reg <= cfg.data[ctlm_pkg::PERIOD_W-1:0];
                    ctlm_pkg::CFG_INVALID_CTX:
                        inv_reg <= cfg.data[ctlm_pkg::CTX_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            cur_reg <= cur_next;
            if (saved_we)
            begin
                saved_reg[ctx_idx] <= cur_reg;
            end
            istart_reg <= istart_next;
            acc_reg    <= acc_next;
            win_reg    <= win_next;
            tick_reg   <= tick_next;
            load_reg   <= load_next;
            upd_reg    <= upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.valid && evt.ready)
        begin
            func_reg <= evt.func;
            ctx_reg  <= evt.ctx_id;
            isr_reg  <= evt.from_isr;
            idle_reg <= evt.idle_running;
            ts_reg   <= evt.timestamp;
        end
        el_reg <= el_next;
        gt_reg <= gt_next;
        if (out_load)
        begin
            out_trace_reg <= cur_reg;
            out_load_reg  <= load_reg;
            out_upd_reg   <= upd_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.trace_pins   = out_trace_reg;
    assign res.cpu_load     = out_load_reg;
    assign res.load_updated = out_upd_reg;

endmodule

### sv/ctlm_div.sv
// Bit-serial restoring divider: one quotient bit per cycle for the load fraction.
module ctlm_div (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ctlm_pkg::div_cmd_t   cmd,
    output ctlm_pkg::div_stat_t  stat
);

    typedef enum logic {D_IDLE, D_RUN} dstate_t;

    dstate_t                             dstate_reg, dstate_next;
    logic [ctlm_pkg::DIV_CNT_W-1:0]      cnt_reg, cnt_next;
    logic                                done_reg, done_next;
    logic [ctlm_pkg::TS_W:0]             rem_reg, rem_next;
    logic [ctlm_pkg::TS_W-1:0]           dvs_reg, dvs_next;
    logic [ctlm_pkg::LOAD_W-1:0]         quo_reg, quo_next;

    logic [ctlm_pkg::TS_W:0]             trial;
    logic                                ge;

    // first step compares the dividend itself, later steps double the remainder
    assign trial = (cnt_reg == '0) ? rem_reg : {rem_reg[ctlm_pkg::TS_W-1:0], 1'b0};
    assign ge    = (trial >= {1'b0, dvs_reg});

    always_comb
    begin
        dstate_next = dstate_reg;
        cnt_next    = cnt_reg;
        done_next   = 1'b0;
        rem_next    = rem_reg;
        dvs_next    = dvs_reg;
        quo_next    = quo_reg;
        case (dstate_reg)
            D_IDLE:
            begin
                if (cmd.start)
                begin
                    rem_next    = {1'b0, cmd.dividend};
                    dvs_next    = cmd.divisor;
                    cnt_next    = '0;
                    dstate_next = D_RUN;
                end
            end
            D_RUN:
            begin
                rem_next = ge ? (trial - {1'b0, dvs_reg}) : trial;
                quo_next = {quo_reg[ctlm_pkg::LOAD_W-2:0], ge};
                cnt_next = ctlm_pkg::DIV_CNT_W'(cnt_reg + 1'b1);
                if (cnt_reg == ctlm_pkg::DIV_CNT_W'(ctlm_pkg::DIV_STEPS - 1))
                begin
                    done_next   = 1'b1;
                    dstate_next = D_IDLE;
                end
            end
            default:
            begin
                dstate_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dstate_reg <= D_IDLE;
            cnt_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            dstate_reg <= dstate_next;
            cnt_reg    <= cnt_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign stat.done     = done_reg;
    assign stat.quotient = quo_reg;

endmodule

### sv/ctlm_checker.sv
// Checker: port-level assertions for the monitor, bound to the top level.
module ctlm_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          evt_valid,
    input logic                          evt_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [ctlm_pkg::CTX_W-1:0]    trace_pins,
    input logic [ctlm_pkg::LOAD_W-1:0]   cpu_load,
    input logic                          load_updated
);

    logic [1:0] pending_reg;
    logic       in_acc;
    logic       out_acc;

    assign in_acc  = evt_valid && evt_ready;
    assign out_acc = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= 2'(pending_reg + {1'b0, in_acc} - {1'b0, out_acc});
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(trace_pins) &&
        $stable(cpu_load) && $stable(load_updated))
        else $error("result changed while stalled");

    a_load_range: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> cpu_load <= ctlm_pkg::LOAD_MAX)
        else $error("cpu load above one");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> pending_reg != 2'd0)
        else $error("result without request");

    a_two_deep: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == 2'd2 |-> !evt_ready)
        else $error("request taken with two in flight");

endmodule

bind context_trace_and_cpu_load_monitor ctlm_checker u_ctlm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .evt_valid    (evt.valid),
    .evt_ready    (evt.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .trace_pins   (res.trace_pins),
    .cpu_load     (res.cpu_load),
    .load_updated (res.load_updated)
);
